/* sv/sasi_pkg.sv */
// ----------------------------------------------------------------------------
// sasi_pkg
// Shared constants and types of the segment / box slab intersection block.
// ----------------------------------------------------------------------------
`default_nettype none

package sasi_pkg;

  // Coordinate width default and Q16.16 interval format
  localparam int unsigned COORD_WIDTH_DEF = 32;
  localparam int unsigned AXES            = 3;
  localparam int unsigned FRAC_BITS       = 16;
  localparam int unsigned TW              = 32;   // width of a t value
  localparam int unsigned THR_W           = 17;   // threshold register width
  localparam logic [THR_W-1:0] THR_RESET  = 17'd1;

  // Quotient: 31 magnitude bits, saturated at an integer part of 2^15 or more
  localparam int unsigned QUO_BITS = TW - 1;
  localparam int unsigned LOW_BITS = QUO_BITS - FRAC_BITS;

  localparam logic [TW-1:0] T_ZERO    = 32'h0000_0000;
  localparam logic [TW-1:0] T_ONE     = 32'h0001_0000;
  localparam logic [TW-1:0] T_POS_MAX = 32'h7FFF_FFFF;
  localparam logic [TW-1:0] T_NEG_MIN = 32'h8000_0000;

  // Pipeline latencies
  localparam int unsigned DIV_LAT     = QUO_BITS + 2;
  localparam int unsigned CLIP_LAT    = 2;
  localparam int unsigned CONTACT_LAT = 2;
  localparam int unsigned SIDE_LAT    = DIV_LAT + CLIP_LAT;

  // Control travelling into the interval clipper
  typedef struct packed {
    logic             valid;
    logic             pmiss;
    logic [AXES-1:0]  clip_en;
  } sasi_clip_ctl_t;

  // Control travelling into the contact stage
  typedef struct packed {
    logic valid;
    logic hit;
  } sasi_ctl_t;

endpackage

`default_nettype wire

/* sv/segment_aabb_slab_intersect.sv */
// ----------------------------------------------------------------------------
// segment_aabb_slab_intersect
// Segment versus axis-aligned box test by the slab method, Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   Pulse start_i with the segment and box on the input ports; the item is
//   taken at that edge. busy_o is always low, so one item per cycle enters.
//   Each item gives one result: done_o is high for exactly
//   one cycle with hit_o and the six contact ports. On a miss the contacts
//   are zero. The receiver cannot hold results off and none is needed: the
//   pipeline never stalls.
//   Pipeline: differences and magnitudes in stages P and M, then the
//   six parallel bit-per-stage dividers (one stage per quotient bit), then
//   interval clipping, then multiply and add.
//   Throughput: one item per cycle.
//   parallel_threshold_we_i writes the threshold register; write it only
//   while no item is in flight. Reset clears all valid bits and sets the
//   threshold to one LSB.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_aabb_slab_intersect import sasi_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          parallel_threshold_we_i,
  input  wire logic [THR_W-1:0]              parallel_threshold_i,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic signed [COORD_WIDTH-1:0] seg_start_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] seg_start_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] seg_start_z_i,
  input  wire logic signed [COORD_WIDTH-1:0] seg_end_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] seg_end_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] seg_end_z_i,
  input  wire logic signed [COORD_WIDTH-1:0] box_min_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] box_min_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] box_min_z_i,
  input  wire logic signed [COORD_WIDTH-1:0] box_max_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] box_max_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] box_max_z_i,
  output logic                               done_o,
  output logic                               hit_o,
  output logic signed [COORD_WIDTH-1:0]      contact_min_x_o,
  output logic signed [COORD_WIDTH-1:0]      contact_min_y_o,
  output logic signed [COORD_WIDTH-1:0]      contact_min_z_o,
  output logic signed [COORD_WIDTH-1:0]      contact_max_x_o,
  output logic signed [COORD_WIDTH-1:0]      contact_max_y_o,
  output logic signed [COORD_WIDTH-1:0]      contact_max_z_o
);

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned CW = (W > THR_W) ? W : THR_W;

  logic [THR_W-1:0] thr_q;
  logic [W-1:0]     s_in  [AXES];
  logic [W-1:0]     e_in  [AXES];
  logic [W-1:0]     lo_in [AXES];
  logic [W-1:0]     hi_in [AXES];

  // Stage P registers
  logic             valid_p_q;
  logic [W-1:0]     s_p_q   [AXES];
  logic [W:0]       d_p_q   [AXES];
  logic [W:0]       nlo_p_q [AXES];
  logic [W:0]       nhi_p_q [AXES];
  logic             out_p_q [AXES];

  // Stage M registers
  logic [W-1:0]     s_m_q     [AXES];
  logic [W-1:0]     dmag_m_q  [AXES];
  logic             dneg_m_q  [AXES];
  logic [W-1:0]     nlo_m_q   [AXES];
  logic [W-1:0]     nhi_m_q   [AXES];
  logic             neglo_m_q [AXES];
  logic             neghi_m_q [AXES];
  sasi_clip_ctl_t   ctl_m_d, ctl_m_q;
  logic [W-1:0]     dmag_d  [AXES];
  logic [W-1:0]     nlo_d   [AXES];
  logic [W-1:0]     nhi_d   [AXES];

  // Side lines past the dividers
  sasi_clip_ctl_t   ctl_dly_q  [DIV_LAT];
  logic [W-1:0]     s_dly_q    [SIDE_LAT][AXES];
  logic [W-1:0]     dmag_dly_q [SIDE_LAT][AXES];
  logic             dneg_dly_q [SIDE_LAT][AXES];

  logic signed [TW-1:0] t1 [AXES];
  logic signed [TW-1:0] t2 [AXES];
  logic signed [TW-1:0] tmin, tmax;
  sasi_ctl_t            clip_ctl;
  logic [W-1:0]         cmin [AXES];
  logic [W-1:0]         cmax [AXES];

  assign busy_o = 1'b0;

  assign s_in[0]  = seg_start_x_i;
  assign s_in[1]  = seg_start_y_i;
  assign s_in[2]  = seg_start_z_i;
  assign e_in[0]  = seg_end_x_i;
  assign e_in[1]  = seg_end_y_i;
  assign e_in[2]  = seg_end_z_i;
  assign lo_in[0] = box_min_x_i;
  assign lo_in[1] = box_min_y_i;
  assign lo_in[2] = box_min_z_i;
  assign hi_in[0] = box_max_x_i;
  assign hi_in[1] = box_max_y_i;
  assign hi_in[2] = box_max_z_i;

  // Threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (parallel_threshold_we_i) begin
      thr_q <= parallel_threshold_i;
    end
  end

  // Stage P: direction, slab offsets, outside flags
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < AXES; i++) begin
      s_p_q[i]   <= s_in[i];
      d_p_q[i]   <= {e_in[i][W-1], e_in[i]} - {s_in[i][W-1], s_in[i]};
      nlo_p_q[i] <= {lo_in[i][W-1], lo_in[i]} - {s_in[i][W-1], s_in[i]};
      nhi_p_q[i] <= {hi_in[i][W-1], hi_in[i]} - {s_in[i][W-1], s_in[i]};
      out_p_q[i] <= ($signed(s_in[i]) <= $signed(lo_in[i])) ||
                    ($signed(s_in[i]) >= $signed(hi_in[i]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_p_q <= 1'b0;
    end else begin
      valid_p_q <= start_i && !busy_o;
    end
  end

  // Stage M: magnitudes, quotient signs, parallel test
  always_comb begin
    ctl_m_d.valid   = valid_p_q;
    ctl_m_d.pmiss   = 1'b0;
    ctl_m_d.clip_en = '0;
    for (int i = 0; i < AXES; i++) begin
      logic [W:0] dabs, loabs, hiabs;
      logic       par;
      dabs  = d_p_q[i][W]   ? ((W+1)'(0) - d_p_q[i])   : d_p_q[i];
      loabs = nlo_p_q[i][W] ? ((W+1)'(0) - nlo_p_q[i]) : nlo_p_q[i];
      hiabs = nhi_p_q[i][W] ? ((W+1)'(0) - nhi_p_q[i]) : nhi_p_q[i];
      dmag_d[i] = dabs[W-1:0];
      nlo_d[i]  = loabs[W-1:0];
      nhi_d[i]  = hiabs[W-1:0];
      par = (CW'(dabs[W-1:0]) < CW'(thr_q)) || (d_p_q[i] == '0);
      ctl_m_d.pmiss      = ctl_m_d.pmiss || (par && out_p_q[i]);
      ctl_m_d.clip_en[i] = (d_p_q[i] != '0);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < AXES; i++) begin
      s_m_q[i]     <= s_p_q[i];
      dmag_m_q[i]  <= dmag_d[i];
      dneg_m_q[i]  <= d_p_q[i][W];
      nlo_m_q[i]   <= nlo_d[i];
      nhi_m_q[i]   <= nhi_d[i];
      neglo_m_q[i] <= nlo_p_q[i][W] != d_p_q[i][W];
      neghi_m_q[i] <= nhi_p_q[i][W] != d_p_q[i][W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_m_q <= '0;
    end else begin
      ctl_m_q <= ctl_m_d;
    end
  end

  // Six dividers: lower- and upper-slab parameter per axis
  for (genvar a = 0; a < AXES; a++) begin : g_axis
    sasi_div #(.W(W)) u_div_lo (
      .clk_i (clk_i),
      .num_i (nlo_m_q[a]),
      .den_i (dmag_m_q[a]),
      .neg_i (neglo_m_q[a]),
      .t_o   (t1[a])
    );
    sasi_div #(.W(W)) u_div_hi (
      .clk_i (clk_i),
      .num_i (nhi_m_q[a]),
      .den_i (dmag_m_q[a]),
      .neg_i (neghi_m_q[a]),
      .t_o   (t2[a])
    );
  end

  // Control line matching the divider latency
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DIV_LAT; k++) ctl_dly_q[k] <= '0;
    end else begin
      ctl_dly_q[0] <= ctl_m_q;
      for (int k = 1; k < DIV_LAT; k++) ctl_dly_q[k] <= ctl_dly_q[k-1];
    end
  end

  // Payload line to the contact stage
  always_ff @(posedge clk_i) begin
    s_dly_q[0]    <= s_m_q;
    dmag_dly_q[0] <= dmag_m_q;
    dneg_dly_q[0] <= dneg_m_q;
    for (int k = 1; k < SIDE_LAT; k++) begin
      s_dly_q[k]    <= s_dly_q[k-1];
      dmag_dly_q[k] <= dmag_dly_q[k-1];
      dneg_dly_q[k] <= dneg_dly_q[k-1];
    end
  end

  sasi_clip u_clip (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl_dly_q[DIV_LAT-1]),
    .t1_i   (t1),
    .t2_i   (t2),
    .ctl_o  (clip_ctl),
    .tmin_o (tmin),
    .tmax_o (tmax)
  );

  sasi_contact #(.W(W)) u_contact (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (clip_ctl),
    .s_i    (s_dly_q[SIDE_LAT-1]),
    .dmag_i (dmag_dly_q[SIDE_LAT-1]),
    .dneg_i (dneg_dly_q[SIDE_LAT-1]),
    .tmin_i (tmin),
    .tmax_i (tmax),
    .done_o (done_o),
    .hit_o  (hit_o),
    .cmin_o (cmin),
    .cmax_o (cmax)
  );

  assign contact_min_x_o = cmin[0];
  assign contact_min_y_o = cmin[1];
  assign contact_min_z_o = cmin[2];
  assign contact_max_x_o = cmax[0];
  assign contact_max_y_o = cmax[1];
  assign contact_max_z_o = cmax[2];

  // Checks
  a_hit_has_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_o |-> done_o)
    else $error("hit without result strobe");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !hit_o |-> (contact_min_x_o == '0 && contact_min_y_o == '0 &&
                contact_min_z_o == '0 && contact_max_x_o == '0 &&
                contact_max_y_o == '0 && contact_max_z_o == '0))
    else $error("nonzero contact on miss");

  a_clip_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clip_ctl.hit |-> (tmin <= tmax && tmin >= $signed(T_ZERO) &&
                      tmax <= $signed(T_ONE)))
    else $error("hit with interval out of order");

  // contact stage passes the strobe through ctl_q, then done_q
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clip_ctl.valid |-> ##2 done_o)
    else $error("clipped item lost before output");

endmodule

`default_nettype wire

/* sv/sasi_div.sv */
// ----------------------------------------------------------------------------
// sasi_div
// Pipelined restoring divider: Q16.16 quotient of two magnitudes, one
// quotient bit per stage, truncated toward zero, signed and saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module sasi_div import sasi_pkg::*; #(
  parameter int unsigned W = COORD_WIDTH_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic [W-1:0]         num_i,
  input  wire logic [W-1:0]         den_i,
  input  wire logic                 neg_i,
  output logic signed [TW-1:0]      t_o
);

  logic [W-1:0]          rem_q [QUO_BITS+1];
  logic [QUO_BITS-1:0]   quo_q [QUO_BITS+1];
  logic [W-1:0]          den_q [QUO_BITS+1];
  logic [LOW_BITS-1:0]   low_q [QUO_BITS+1];
  logic                  neg_q [QUO_BITS+1];
  logic                  sat_q [QUO_BITS+1];
  logic [TW-1:0]         t_d;
  logic [TW-1:0]         t_q;

  // Entry: saturation check and initial partial remainder
  always_ff @(posedge clk_i) begin
    sat_q[0] <= {{LOW_BITS{1'b0}}, num_i} >= {den_i, {LOW_BITS{1'b0}}};
    rem_q[0] <= W'(num_i >> LOW_BITS);
    low_q[0] <= num_i[LOW_BITS-1:0];
    quo_q[0] <= '0;
    den_q[0] <= den_i;
    neg_q[0] <= neg_i;
  end

  // One quotient bit per stage
  for (genvar j = 0; j < QUO_BITS; j++) begin : g_step
    logic         in_bit;
    logic [W:0]   trial;
    logic         ge;

    if (j < LOW_BITS) begin : g_low
      assign in_bit = low_q[j][LOW_BITS-1-j];
    end else begin : g_zero
      assign in_bit = 1'b0;
    end

    assign trial = {rem_q[j], in_bit};
    assign ge    = trial >= {1'b0, den_q[j]};

    always_ff @(posedge clk_i) begin
      rem_q[j+1] <= ge ? W'(trial - {1'b0, den_q[j]}) : trial[W-1:0];
      quo_q[j+1] <= {quo_q[j][QUO_BITS-2:0], ge};
      den_q[j+1] <= den_q[j];
      low_q[j+1] <= low_q[j];
      neg_q[j+1] <= neg_q[j];
      sat_q[j+1] <= sat_q[j];
    end
  end

  // Sign and saturation
  always_comb begin
    if (sat_q[QUO_BITS]) begin
      t_d = neg_q[QUO_BITS] ? T_NEG_MIN : T_POS_MAX;
    end else if (neg_q[QUO_BITS]) begin
      t_d = T_ZERO - {1'b0, quo_q[QUO_BITS]};
    end else begin
      t_d = {1'b0, quo_q[QUO_BITS]};
    end
  end

  always_ff @(posedge clk_i) begin
    t_q <= t_d;
  end

  assign t_o = $signed(t_q);

endmodule

`default_nettype wire

/* sv/sasi_clip.sv */
// ----------------------------------------------------------------------------
// sasi_clip
// Orders each axis' parameter pair and clips the [0, 1] interval; two stages.
// ----------------------------------------------------------------------------
`default_nettype none

module sasi_clip import sasi_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire sasi_clip_ctl_t        ctl_i,
  input  wire logic signed [TW-1:0]  t1_i [AXES],
  input  wire logic signed [TW-1:0]  t2_i [AXES],
  output sasi_ctl_t                  ctl_o,
  output logic signed [TW-1:0]       tmin_o,
  output logic signed [TW-1:0]       tmax_o
);

  logic signed [TW-1:0] lo_d [AXES];
  logic signed [TW-1:0] hi_d [AXES];
  logic signed [TW-1:0] lo_q [AXES];
  logic signed [TW-1:0] hi_q [AXES];
  logic                 valid_q;
  logic                 pmiss_q;
  logic signed [TW-1:0] tmin_d, tmax_d;
  logic signed [TW-1:0] tmin_q, tmax_q;
  sasi_ctl_t            ctl_d, ctl_q;

  // Stage 1: order each pair, neutral bounds for axes without constraint
  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      if (!ctl_i.clip_en[i]) begin
        lo_d[i] = $signed(T_ZERO);
        hi_d[i] = $signed(T_ONE);
      end else if (t1_i[i] > t2_i[i]) begin
        lo_d[i] = t2_i[i];
        hi_d[i] = t1_i[i];
      end else begin
        lo_d[i] = t1_i[i];
        hi_d[i] = t2_i[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d;
    hi_q <= hi_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pmiss_q <= 1'b0;
    end else begin
      valid_q <= ctl_i.valid;
      pmiss_q <= ctl_i.pmiss;
    end
  end

  // Stage 2: running max of entries, min of exits
  always_comb begin
    tmin_d = $signed(T_ZERO);
    tmax_d = $signed(T_ONE);
    for (int i = 0; i < AXES; i++) begin
      if (lo_q[i] > tmin_d) tmin_d = lo_q[i];
      if (hi_q[i] < tmax_d) tmax_d = hi_q[i];
    end
    ctl_d.valid = valid_q;
    ctl_d.hit   = valid_q && !pmiss_q && (tmin_d <= tmax_d);
  end

  always_ff @(posedge clk_i) begin
    tmin_q <= tmin_d;
    tmax_q <= tmax_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_d;
    end
  end

  assign ctl_o  = ctl_q;
  assign tmin_o = tmin_q;
  assign tmax_o = tmax_q;

endmodule

`default_nettype wire

/* sv/sasi_contact.sv */
// ----------------------------------------------------------------------------
// sasi_contact
// Contact points S + D*t for entry and exit: multiply stage, then add stage.
// ----------------------------------------------------------------------------
`default_nettype none

module sasi_contact import sasi_pkg::*; #(
  parameter int unsigned W = COORD_WIDTH_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire sasi_ctl_t            ctl_i,
  input  wire logic [W-1:0]         s_i    [AXES],
  input  wire logic [W-1:0]         dmag_i [AXES],
  input  wire logic                 dneg_i [AXES],
  input  wire logic signed [TW-1:0] tmin_i,
  input  wire logic signed [TW-1:0] tmax_i,
  output logic                      done_o,
  output logic                      hit_o,
  output logic [W-1:0]              cmin_o [AXES],
  output logic [W-1:0]              cmax_o [AXES]
);

  localparam int unsigned PW = W + FRAC_BITS + 1;

  logic [PW-1:0]  pmin_q [AXES];
  logic [PW-1:0]  pmax_q [AXES];
  logic [W-1:0]   s_q    [AXES];
  logic           dneg_q [AXES];
  sasi_ctl_t      ctl_q;
  logic [W-1:0]   cmin_d [AXES];
  logic [W-1:0]   cmax_d [AXES];
  logic [W-1:0]   cmin_q [AXES];
  logic [W-1:0]   cmax_q [AXES];
  logic           done_q, hit_q;

  // Stage 1: |D| * t, t in [0, 1]
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < AXES; i++) begin
      pmin_q[i] <= PW'(dmag_i[i]) * PW'(tmin_i[FRAC_BITS:0]);
      pmax_q[i] <= PW'(dmag_i[i]) * PW'(tmax_i[FRAC_BITS:0]);
      s_q[i]    <= s_i[i];
      dneg_q[i] <= dneg_i[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  // Stage 2: truncate, restore sign, add start; zero on miss
  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      logic [W-1:0] smin, smax;
      smin = pmin_q[i][FRAC_BITS +: W];
      smax = pmax_q[i][FRAC_BITS +: W];
      if (!ctl_q.hit) begin
        cmin_d[i] = '0;
        cmax_d[i] = '0;
      end else if (dneg_q[i]) begin
        cmin_d[i] = s_q[i] - smin;
        cmax_d[i] = s_q[i] - smax;
      end else begin
        cmin_d[i] = s_q[i] + smin;
        cmax_d[i] = s_q[i] + smax;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
      hit_q  <= 1'b0;
      for (int i = 0; i < AXES; i++) begin
        cmin_q[i] <= '0;
        cmax_q[i] <= '0;
      end
    end else begin
      done_q <= ctl_q.valid;
      hit_q  <= ctl_q.valid && ctl_q.hit;
      cmin_q <= cmin_d;
      cmax_q <= cmax_d;
    end
  end

  assign done_o = done_q;
  assign hit_o  = hit_q;
  assign cmin_o = cmin_q;
  assign cmax_o = cmax_q;

endmodule

`default_nettype wire
